// ----- sv/nsfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next smooth FFT length: shared package
// Constants, codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package nsfl_pkg;

   localparam int LENGTH_WIDTH_DEF = 24;

   localparam logic [1:0] MODE_ANY  = 2'd0;
   localparam logic [1:0] MODE_EVEN = 2'd1;
   localparam logic [1:0] MODE_ODD  = 2'd2;

   localparam logic [2:0] PSEL_TWO      = 3'd0;
   localparam logic [2:0] PSEL_THREE    = 3'd1;
   localparam logic [2:0] PSEL_FIVE     = 3'd2;
   localparam logic [2:0] PSEL_SEVEN    = 3'd3;
   localparam logic [2:0] PSEL_ELEVEN   = 3'd4;
   localparam logic [2:0] PSEL_THIRTEEN = 3'd5;

   // Multiplicative inverses of the odd primes modulo 2^64; the low bits give
   // the inverse for any narrower word.
   localparam logic [63:0] INV_THREE    = 64'hAAAA_AAAA_AAAA_AAAB;
   localparam logic [63:0] INV_FIVE     = 64'hCCCC_CCCC_CCCC_CCCD;
   localparam logic [63:0] INV_SEVEN    = 64'h6DB6_DB6D_B6DB_6DB7;
   localparam logic [63:0] INV_ELEVEN   = 64'h2E8B_A2E8_BA2E_8BA3;
   localparam logic [63:0] INV_THIRTEEN = 64'h4EC4_EC4E_C4EC_4EC5;

   typedef struct packed {
      logic load_req;
      logic inc_cand;
      logic load_rem;
      logic div_start;
      logic take_quot;
      logic next_prime;
      logic out_load;
   } nsfl_cmd_type;

   typedef struct packed {
      logic small_req;
      logic parity_ok;
      logic divisible;
      logic repeat_prime;
      logic last_prime;
      logic rem_is_one;
      logic out_free;
   } nsfl_sts_type;

endpackage

// ----- sv/next_smooth_fft_length.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next smooth FFT length
// Returns the smallest length >= the request (a request <= 2 as it is) of
// the form 2^a*3^b*5^c*7^d*11^e*13^f (e, f at most 1) meeting its parity mode.
//
//   Channel  Direction  Payload
//   req_     in         requested_length, parity_mode
//   rsp_     out        chosen_length
//
// One item is searched at a time; req_tready is high only while idle.
// Each candidate takes a parity test in ST_CHECK, and each trial division
// forms the quotient in ST_START (a shift for two, else the product with the
// inverse of the prime) and tests it in ST_EVAL, plus ST_ADVANCE per prime
// step; the number of candidates sets the total.
// Reset is synchronous and clears the controller, the candidate, remainder
// and prime select registers and the result valid flag.
// A stalled result is held in the output register while the next request is
// still taken.
// ----------------------------------------------------------------------------
module next_smooth_fft_length
   import nsfl_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // requested_length [LENGTH_WIDTH-1:0], parity_mode, zero fill
   input  logic [((LENGTH_WIDTH + 2 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // chosen_length [LENGTH_WIDTH+1:0], zero fill
   output logic [((LENGTH_WIDTH + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int TW = ((LENGTH_WIDTH + 2 + 7) / 8) * 8;

   nsfl_cmd_type            cmd;
   nsfl_sts_type            sts;
   logic                    idle;
   logic                    req_accept;
   logic [LENGTH_WIDTH+1:0] rsp_length;

   assign req_tready = idle;
   assign req_accept = req_tvalid & idle;

   nsfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .sts        (sts),
      .cmd        (cmd),
      .idle       (idle)
   );

   nsfl_dp #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_length (req_tdata[LENGTH_WIDTH-1:0]),
      .req_mode   (req_tdata[LENGTH_WIDTH+1:LENGTH_WIDTH]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_length (rsp_length)
   );

   assign rsp_tdata = TW'(rsp_length);

endmodule

// ----- sv/nsfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next smooth FFT length: controller
// Sequences the candidate search and the trial divisions.
// ----------------------------------------------------------------------------
module nsfl_ctrl
   import nsfl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_accept,
   input  nsfl_sts_type sts,
   output nsfl_cmd_type cmd,
   output logic         idle
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CHECK   = 6'b000010,
      ST_START   = 6'b000100,
      ST_EVAL    = 6'b001000,
      ST_ADVANCE = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.small_req) begin
               state_in = ST_DONE;
            end else if (sts.parity_ok) begin
               cmd.load_rem = 1'b1;
               state_in     = ST_START;
            end else begin
               cmd.inc_cand = 1'b1;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.divisible) begin
               cmd.take_quot = 1'b1;
               state_in      = sts.repeat_prime ? ST_START : ST_ADVANCE;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            if (!sts.last_prime) begin
               cmd.next_prime = 1'b1;
               state_in       = ST_START;
            end else if (sts.rem_is_one) begin
               state_in = ST_DONE;
            end else begin
               cmd.inc_cand = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// ----- sv/nsfl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next smooth FFT length: datapath
// Candidate counter, remainder register, exact division (two by shift, odd
// primes through multiplication with the inverse), and the result register.
// ----------------------------------------------------------------------------
module nsfl_dp
   import nsfl_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [LENGTH_WIDTH-1:0]   req_length,
   input  logic [1:0]                req_mode,
   input  nsfl_cmd_type              cmd,
   output nsfl_sts_type              sts,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [LENGTH_WIDTH+1:0]   rsp_length
);

   localparam int OW = LENGTH_WIDTH + 2;

   localparam logic [63:0]   OW_MAX        = (64'd1 << OW) - 64'd1;
   localparam logic [OW-1:0] LIM_THREE     = OW'(OW_MAX / 64'd3);
   localparam logic [OW-1:0] LIM_FIVE      = OW'(OW_MAX / 64'd5);
   localparam logic [OW-1:0] LIM_SEVEN     = OW'(OW_MAX / 64'd7);
   localparam logic [OW-1:0] LIM_ELEVEN    = OW'(OW_MAX / 64'd11);
   localparam logic [OW-1:0] LIM_THIRTEEN  = OW'(OW_MAX / 64'd13);

   logic [OW-1:0]         cand_ff, cand_in;
   logic [1:0]            mode_ff, mode_in;
   logic [OW-1:0]         rem_ff, rem_in;
   logic [2:0]            psel_ff, psel_in;
   logic [OW-1:0]         quot_ff, quot_in;
   logic [OW-1:0]         out_ff, out_in;
   logic                  valid_ff, valid_in;
   logic [OW-1:0]         inverse;
   logic [OW-1:0]         limit;
   logic [OW-1:0]         product;

   // A value is a multiple of an odd prime exactly when its product with the
   // inverse stays at or below the limit; the product is then the quotient.
   always_comb begin
      unique case (psel_ff)
         PSEL_THREE: begin
            inverse = INV_THREE[OW-1:0];
            limit   = LIM_THREE;
         end
         PSEL_FIVE: begin
            inverse = INV_FIVE[OW-1:0];
            limit   = LIM_FIVE;
         end
         PSEL_SEVEN: begin
            inverse = INV_SEVEN[OW-1:0];
            limit   = LIM_SEVEN;
         end
         PSEL_ELEVEN: begin
            inverse = INV_ELEVEN[OW-1:0];
            limit   = LIM_ELEVEN;
         end
         PSEL_THIRTEEN: begin
            inverse = INV_THIRTEEN[OW-1:0];
            limit   = LIM_THIRTEEN;
         end
         default: begin
            inverse = '0;
            limit   = '0;
         end
      endcase
   end

   assign product = rem_ff * inverse;

   always_comb begin
      cand_in  = cand_ff;
      mode_in  = mode_ff;
      rem_in   = rem_ff;
      psel_in  = psel_ff;
      quot_in  = quot_ff;
      out_in   = out_ff;
      if (cmd.load_req) begin
         cand_in = {2'b00, req_length};
         mode_in = req_mode;
      end
      if (cmd.inc_cand) begin
         cand_in = cand_ff + OW'(1);
      end
      if (cmd.load_rem) begin
         rem_in  = cand_ff;
         psel_in = PSEL_TWO;
      end
      if (cmd.div_start) begin
         quot_in = (psel_ff == PSEL_TWO) ? {1'b0, rem_ff[OW-1:1]} : product;
      end
      if (cmd.take_quot) begin
         rem_in = quot_ff;
      end
      if (cmd.next_prime) begin
         psel_in = psel_ff + 3'd1;
      end
      if (cmd.out_load) begin
         out_in = cand_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      quot_ff  <= quot_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
         rem_ff  <= '0;
         psel_ff <= PSEL_TWO;
      end else begin
         cand_ff <= cand_in;
         rem_ff  <= rem_in;
         psel_ff <= psel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      sts.small_req    = (cand_ff <= OW'(2));
      case (mode_ff)
         MODE_EVEN: sts.parity_ok = ~cand_ff[0];
         MODE_ODD:  sts.parity_ok = cand_ff[0];
         default:   sts.parity_ok = 1'b1;
      endcase
      sts.divisible    = (rem_ff != '0) &&
                         ((psel_ff == PSEL_TWO) ? ~rem_ff[0] : (quot_ff <= limit));
      sts.repeat_prime = (psel_ff < PSEL_ELEVEN);
      sts.last_prime   = (psel_ff == PSEL_THIRTEEN);
      sts.rem_is_one   = (rem_ff == OW'(1));
      sts.out_free     = ~valid_ff | rsp_tready;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_length = out_ff;

endmodule
